FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CMS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cms assertion failed");

// Next-cycle implication
`define CMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cms assertion failed");

`endif

FILE: design/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Widths, constants and shared types of the CAN message segmenter.
// ----------------------------------------------------------------------------
package cms_pkg;

  // Input word fields
  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned ID_W   = 11;

  // Output word fields
  localparam int unsigned FRAME_W = 64;
  localparam int unsigned FLEN_W  = 4;

  // Frame layout
  localparam int unsigned PAYLOAD_BYTES = 6;
  localparam int unsigned PAYLOAD_W     = PAYLOAD_BYTES * DATA_W;
  localparam int unsigned DESC_W        = 16;
  localparam int unsigned DESC_BYTES    = DESC_W / DATA_W;
  localparam int unsigned FILL_W        = 3;

  // Descriptor fields
  localparam int unsigned FRAME_NUM_W   = 8;
  localparam int unsigned MSG_CNT_W     = 2;
  localparam int unsigned COUNT_W       = 8;
  localparam int unsigned MSG_CNT_SHIFT = 12;
  localparam int unsigned COUNT_SHIFT   = 6;

  // ceil(len/6) via reciprocal: x/6 == (x*683)>>12 for x < 2048
  localparam int unsigned RECIP_6_W     = 10;
  localparam int unsigned RECIP_6       = 683;
  localparam int unsigned RECIP_SHIFT   = 12;
  localparam int unsigned CEIL_W        = LEN_W + 1;

  // Default length limit
  localparam int unsigned MAX_MESSAGE_BYTES_DEF = 512;

  // Descriptor request handed to the descriptor builder
  typedef struct packed {
    logic [LEN_W-1:0]       eff_len;
    logic [MSG_CNT_W-1:0]   msg_cnt;
    logic [FRAME_NUM_W-1:0] frame_num;
  } desc_req_t;

endpackage

FILE: design/cms_in_if.sv
// ----------------------------------------------------------------------------
// cms_in_if
// Input channel: one message byte with its length and CAN identifier.
// ----------------------------------------------------------------------------
interface cms_in_if import cms_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic [LEN_W-1:0]  message_length;
  logic [ID_W-1:0]   can_identifier;

  modport source (output valid, output data_byte, output message_length,
                  output can_identifier, input ready);
  modport sink   (input valid, input data_byte, input message_length,
                  input can_identifier, output ready);

endinterface

FILE: design/cms_out_if.sv
// ----------------------------------------------------------------------------
// cms_out_if
// Output channel: one CAN frame or an oversize error word.
// ----------------------------------------------------------------------------
interface cms_out_if import cms_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_bytes;
  logic [FLEN_W-1:0]  frame_length;
  logic [ID_W-1:0]    frame_identifier;
  logic               last_frame;
  logic               too_long;

  modport source (output valid, output frame_bytes, output frame_length,
                  output frame_identifier, output last_frame, output too_long,
                  input ready);
  modport sink   (input valid, input frame_bytes, input frame_length,
                  input frame_identifier, input last_frame, input too_long,
                  output ready);

endinterface

FILE: design/can_message_segmenter_core.sv
// ----------------------------------------------------------------------------
// can_message_segmenter_core
// Packs a byte stream into classic CAN frames: 16-bit descriptor plus up to
// six payload bytes per frame; oversize messages give one error word.
// ----------------------------------------------------------------------------
// One message byte is taken per clock. A byte that completes a frame (sixth
// payload byte, or the last byte of the message) produces a frame word in the
// output register in the cycle after it is accepted; other bytes produce
// nothing, and an oversize message gives only the error word, on its last byte.
// The input stays ready while the output register is empty or being read, so
// the rate is one byte per cycle; a stalled output stalls the input only once a word waits.
module can_message_segmenter_core import cms_pkg::*; #(
  parameter int unsigned MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  cms_in_if.sink    in_i,
  cms_out_if.source out_o
);

`include "assert_macros.svh"

  // Message state
  logic [LEN_W-1:0]       pos_q, pos_d;
  logic [FRAME_NUM_W-1:0] frame_q, frame_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic [PAYLOAD_W-1:0]   buf_q, buf_d;
  logic [MSG_CNT_W-1:0]   msg_cnt_q, msg_cnt_d;

  // Output register
  logic                   out_valid_q;
  logic [FRAME_W-1:0]     out_bytes_q;
  logic [FLEN_W-1:0]      out_len_q;
  logic [ID_W-1:0]        out_id_q;
  logic                   out_last_q;
  logic                   out_err_q;

  logic                   in_fire;
  logic [LEN_W-1:0]       eff_len;
  logic [LEN_W:0]         pos_inc;
  logic                   is_last;
  logic                   is_drop;
  logic [PAYLOAD_W-1:0]   buf_new;
  logic [FILL_W-1:0]      fill_new;
  logic                   emit;
  desc_req_t              desc_req;
  logic [DESC_W-1:0]      desc;

  // Handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Per-byte decode
  assign eff_len  = (in_i.message_length == '0) ? LEN_W'(1) : in_i.message_length;
  assign pos_inc  = (LEN_W+1)'(pos_q) + (LEN_W+1)'(1);
  assign is_last  = pos_inc >= (LEN_W+1)'(eff_len);
  assign is_drop  = in_i.message_length > LEN_W'(MAX_MESSAGE_BYTES);
  assign buf_new  = buf_q | (PAYLOAD_W'(in_i.data_byte) << {fill_q, 3'b000});
  assign fill_new = fill_q + FILL_W'(1);
  assign emit     = is_drop ? is_last
                            : ((fill_new == FILL_W'(PAYLOAD_BYTES)) || is_last);

  assign desc_req.eff_len   = eff_len;
  assign desc_req.msg_cnt   = msg_cnt_q;
  assign desc_req.frame_num = frame_q;

  cms_descriptor u_desc (
    .req_i  (desc_req),
    .desc_o (desc)
  );

  // Next message state
  always_comb begin
    pos_d     = pos_q;
    frame_d   = frame_q;
    fill_d    = fill_q;
    buf_d     = buf_q;
    msg_cnt_d = msg_cnt_q;
    if (in_fire) begin
      if (is_drop) begin
        if (is_last) begin
          pos_d   = '0;
          frame_d = '0;
          fill_d  = '0;
          buf_d   = '0;
        end else begin
          pos_d = pos_inc[LEN_W-1:0];
        end
      end else if (emit) begin
        fill_d = '0;
        buf_d  = '0;
        if (is_last) begin
          pos_d     = '0;
          frame_d   = '0;
          msg_cnt_d = msg_cnt_q + MSG_CNT_W'(1);
        end else begin
          pos_d   = pos_inc[LEN_W-1:0];
          frame_d = frame_q + FRAME_NUM_W'(1);
        end
      end else begin
        pos_d  = pos_inc[LEN_W-1:0];
        fill_d = fill_new;
        buf_d  = buf_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      frame_q   <= '0;
      fill_q    <= '0;
      buf_q     <= '0;
      msg_cnt_q <= '0;
    end else begin
      pos_q     <= pos_d;
      frame_q   <= frame_d;
      fill_q    <= fill_d;
      buf_q     <= buf_d;
      msg_cnt_q <= msg_cnt_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      if (is_drop) begin
        out_bytes_q <= '0;
        out_len_q   <= '0;
        out_id_q    <= '0;
        out_last_q  <= 1'b0;
        out_err_q   <= 1'b1;
      end else begin
        out_bytes_q <= {buf_new, desc};
        out_len_q   <= FLEN_W'(fill_new) + FLEN_W'(DESC_BYTES);
        out_id_q    <= in_i.can_identifier;
        out_last_q  <= is_last;
        out_err_q   <= 1'b0;
      end
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.frame_bytes      = out_bytes_q;
  assign out_o.frame_length     = out_len_q;
  assign out_o.frame_identifier = out_id_q;
  assign out_o.last_frame       = out_last_q;
  assign out_o.too_long         = out_err_q;

  // Checks
  `CMS_ASSERT_IMPL(a_err_word_clean, out_valid_q && out_err_q,
    (out_bytes_q == '0) && (out_len_q == '0) && (out_id_q == '0) && !out_last_q)
  `CMS_ASSERT_IMPL(a_frame_len_range, out_valid_q && !out_err_q,
    (out_len_q >= FLEN_W'(3)) && (out_len_q <= FLEN_W'(8)))
  `CMS_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q < FILL_W'(PAYLOAD_BYTES))
  `CMS_ASSERT_NEXT(a_msg_cnt_step, in_fire && is_last && !is_drop,
    msg_cnt_q == $past(msg_cnt_q) + MSG_CNT_W'(1))
  `CMS_ASSERT_IMPL(a_ready_when_empty, !out_valid_q, in_i.ready)

endmodule

FILE: design/cms_descriptor.sv
// ----------------------------------------------------------------------------
// cms_descriptor
// Builds the 16-bit frame descriptor: message number, frame count and frame
// index, ORed together and truncated.
// ----------------------------------------------------------------------------
module cms_descriptor import cms_pkg::*; (
  input  desc_req_t         req_i,
  output logic [DESC_W-1:0] desc_o
);

  logic [CEIL_W-1:0]             ceil_num;
  logic [CEIL_W+RECIP_6_W-1:0]   ceil_prod;
  logic [COUNT_W-1:0]            frame_count;

  // frame_count = ceil(len / 6) by reciprocal multiply
  assign ceil_num    = CEIL_W'(req_i.eff_len) + CEIL_W'(PAYLOAD_BYTES - 1);
  assign ceil_prod   = (CEIL_W+RECIP_6_W)'(ceil_num) * (CEIL_W+RECIP_6_W)'(RECIP_6);
  assign frame_count = ceil_prod[RECIP_SHIFT +: COUNT_W];

  // Fields overlap by design; OR and keep the low 16 bits
  assign desc_o = (DESC_W'(req_i.msg_cnt) << MSG_CNT_SHIFT)
                | (DESC_W'(frame_count) << COUNT_SHIFT)
                | DESC_W'(req_i.frame_num);

endmodule
